// ----- hdl/pkrl_pkg.sv -----
// shared types and constants for the per-key rate limiter
package pkrl_pkg;

  localparam int TIME_W   = 32;
  localparam int CNT_W    = 8;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ   = 1'd1;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;
  localparam logic [CNT_W-1:0]  MAXREQ_RESET = 8'd5;
  localparam logic [CNT_W-1:0]  CNT_SAT      = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_HOLD
  } pkrl_state_t;

endpackage

// ----- hdl/pkrl_table.sv -----
// entry table: key, window start and count memories plus per-entry valid bits
module pkrl_table
  import pkrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8,
  parameter int KEY_BITS      = 64,
  parameter int IDX_W         = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic                rd_valid,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [TIME_W-1:0]   rd_ws,
  output logic [CNT_W-1:0]    rd_cnt,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [TIME_W-1:0]   wr_ws,
  input  logic [CNT_W-1:0]    wr_cnt
);

  logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0]   ws_mem  [TABLE_ENTRIES];
  logic [CNT_W-1:0]    cnt_mem [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     rd_valid_r;
  logic [KEY_BITS-1:0]      rd_key_r;
  logic [TIME_W-1:0]        rd_ws_r;
  logic [CNT_W-1:0]         rd_cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      ws_mem[wr_addr]  <= wr_ws;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_ws_r  <= ws_mem[rd_addr];
    rd_cnt_r <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_key_r;
  assign rd_ws    = rd_ws_r;
  assign rd_cnt   = rd_cnt_r;

endmodule

// ----- hdl/per_key_rate_limiter.sv -----
// per-key fixed-window rate limiter: scan sequencer, window update and result register
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_topic_key, in_now_ms
//   out     | output    | out_valid/out_stall | out_allowed, out_slot_index, out_new_entry,
//           |           |                     | out_evicted, out_count_after
//   cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// a word passes through the accept step, then one entry read and compared per cycle over
// the single read port (a key hit ends the scan early), then an update step through the
// shared subtract/compare unit that also writes the entry back
// reset clears the valid bits, the sequencer and the output register; no clearing pass
// the next word is taken while a result still waits on out_stall; a finished result
// that finds the output register full is parked until it drains
module per_key_rate_limiter
  import pkrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8,
  parameter int KEY_BITS      = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_topic_key,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_allowed,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic                 out_new_entry,
  output logic                 out_evicted,
  output logic [CNT_W-1:0]     out_count_after,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  pkrl_state_t state_r, state_nxt;

  logic [TIME_W-1:0]   window_r;
  logic [CNT_W-1:0]    max_req_r;

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [TIME_W-1:0]   ent_ws_r, ent_ws_nxt;
  logic [CNT_W-1:0]    ent_cnt_r, ent_cnt_nxt;
  logic                fresh_r, fresh_nxt;
  logic                evict_r, evict_nxt;

  logic                res_allowed_r, res_allowed_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                res_fresh_r, res_fresh_nxt;
  logic                res_evict_r, res_evict_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_allowed_r, out_allowed_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_fresh_r, out_fresh_nxt;
  logic                out_evict_r, out_evict_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [IDX_W-1:0]    rd_addr;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [TIME_W-1:0]   rd_ws;
  logic [CNT_W-1:0]    rd_cnt;
  logic                wr_en;
  logic [TIME_W-1:0]   wr_ws;
  logic [CNT_W-1:0]    wr_cnt;

  logic                in_acc;
  logic                out_free;
  logic                hit;
  logic [TIME_W-1:0]   elapsed;
  logic                restart;
  logic [CNT_W-1:0]    base_cnt;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  pkrl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_ws    (rd_ws),
    .rd_cnt   (rd_cnt),
    .wr_en    (wr_en),
    .wr_addr  (slot_r),
    .wr_key   (key_r),
    .wr_ws    (wr_ws),
    .wr_cnt   (wr_cnt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RESET;
      max_req_r <= MAXREQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_MS: window_r  <= cfg_wdata;
        REG_MAX_REQ:   max_req_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign hit      = rd_valid && (rd_key == key_r);

  // shared window unit: wrapping elapsed time against the window length
  assign elapsed  = now_r - ent_ws_r;
  assign restart  = (elapsed >= window_r);
  assign base_cnt = restart ? '0 : ent_cnt_r;
  assign wr_cnt   = (base_cnt == CNT_SAT) ? CNT_SAT : base_cnt + 1'b1;
  assign wr_ws    = restart ? now_r : ent_ws_r;
  assign wr_en    = (state_r == ST_UPD);
  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    slot_r        <= slot_nxt;
    ent_ws_r      <= ent_ws_nxt;
    ent_cnt_r     <= ent_cnt_nxt;
    fresh_r       <= fresh_nxt;
    evict_r       <= evict_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_slot_r    <= res_slot_nxt;
    res_fresh_r   <= res_fresh_nxt;
    res_evict_r   <= res_evict_nxt;
    res_cnt_r     <= res_cnt_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_slot_r    <= out_slot_nxt;
    out_fresh_r   <= out_fresh_nxt;
    out_evict_r   <= out_evict_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    slot_nxt        = slot_r;
    ent_ws_nxt      = ent_ws_r;
    ent_cnt_nxt     = ent_cnt_r;
    fresh_nxt       = fresh_r;
    evict_nxt       = evict_r;
    res_allowed_nxt = res_allowed_r;
    res_slot_nxt    = res_slot_r;
    res_fresh_nxt   = res_fresh_r;
    res_evict_nxt   = res_evict_r;
    res_cnt_nxt     = res_cnt_r;
    out_allowed_nxt = out_allowed_r;
    out_slot_nxt    = out_slot_r;
    out_fresh_nxt   = out_fresh_r;
    out_evict_nxt   = out_evict_r;
    out_cnt_nxt     = out_cnt_r;
    out_valid_nxt   = out_free ? 1'b0 : out_valid_r;
    rd_addr         = '0;

    case (state_r)
      ST_IDLE: begin
        // entry 0 is read every idle cycle so the scan starts with data in hand
        if (in_acc) begin
          key_nxt        = in_topic_key[KEY_BITS-1:0];
          now_nxt        = in_now_ms;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        if (hit) begin
          slot_nxt    = idx_r;
          ent_ws_nxt  = rd_ws;
          ent_cnt_nxt = rd_cnt;
          fresh_nxt   = 1'b0;
          evict_nxt   = 1'b0;
          state_nxt   = ST_UPD;
        end else if (idx_r == LAST_IDX) begin
          // miss: first free entry, else overwrite entry 0
          fresh_nxt   = 1'b1;
          ent_ws_nxt  = now_r;
          ent_cnt_nxt = '0;
          if (free_found_r) begin
            slot_nxt  = free_idx_r;
            evict_nxt = 1'b0;
          end else if (!rd_valid) begin
            slot_nxt  = idx_r;
            evict_nxt = 1'b0;
          end else begin
            slot_nxt  = '0;
            evict_nxt = 1'b1;
          end
          state_nxt = ST_UPD;
        end else begin
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        res_allowed_nxt = (wr_cnt <= max_req_r);
        res_slot_nxt    = slot_ext[SLOT_W-1:0];
        res_fresh_nxt   = fresh_r;
        res_evict_nxt   = evict_r;
        res_cnt_nxt     = wr_cnt;
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = (wr_cnt <= max_req_r);
          out_slot_nxt    = slot_ext[SLOT_W-1:0];
          out_fresh_nxt   = fresh_r;
          out_evict_nxt   = evict_r;
          out_cnt_nxt     = wr_cnt;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_slot_nxt    = res_slot_r;
          out_fresh_nxt   = res_fresh_r;
          out_evict_nxt   = res_evict_r;
          out_cnt_nxt     = res_cnt_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_allowed     = out_allowed_r;
  assign out_slot_index  = out_slot_r;
  assign out_new_entry   = out_fresh_r;
  assign out_evicted     = out_evict_r;
  assign out_count_after = out_cnt_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN) && (idx_r == '0))
    else $error("accepted word did not start a scan at entry 0");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= LAST_IDX))
    else $error("scan index past the last table entry");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != '0))
    else $error("result carries a zero count");

  a_evict_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evict_r) |-> (out_fresh_r && (out_slot_r == '0)))
    else $error("eviction reported on a slot other than entry 0");

  a_allowed_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_allowed_r == (out_cnt_r <= max_req_r)))
    else $error("allowed flag disagrees with count and limit");

endmodule
